FILE: design/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared constants and types for the frustum box cull block
// register layout, plane ordering and fixed-point widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF = 32;  // signed Q16.16 box coordinates
  localparam int ENTRY_WIDTH_DEF = 16;  // signed Q3.12 matrix entries

  // register layout
  localparam int REG_WIDTH       = 64;
  localparam int SLOT_WIDTH      = 16;
  localparam int NUM_ROWS        = 4;
  localparam int NUM_COLS        = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  // geometry
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;
  localparam int NEAR_PLANE = 4;   // row3 + row2
  localparam int W_ROW      = 3;   // row that every plane adds to
  localparam int D_COL      = 3;   // column holding the plane offset
  localparam int FRAC_BITS  = 16;  // coordinate fraction bits

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW_0 = 2'd0,
    REG_ROW_1 = 2'd1,
    REG_ROW_2 = 2'd2,
    REG_ROW_3 = 2'd3
  } reg_index_t;

  // identity matrix at reset
  localparam logic [REG_WIDTH-1:0] ROW_0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [REG_WIDTH-1:0] ROW_1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [REG_WIDTH-1:0] ROW_2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [REG_WIDTH-1:0] ROW_3_RESET = 64'h1000_0000_0000_0000;

endpackage

`default_nettype wire

FILE: design/fbc_plane_setup.sv
// ----------------------------------------------------------------------------
// fbc_plane_setup: plane coefficients and p-vertex selection
// forms the six planes from the matrix rows and picks the corner per plane
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbc_plane_setup #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int ENTRY_WIDTH = fbc_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  adv,
  input  logic [fbc_pkg::NUM_ROWS-1:0][fbc_pkg::REG_WIDTH-1:0]  rows,
  input  logic signed [COORD_WIDTH-1:0]                         box_min [fbc_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]                         box_max [fbc_pkg::NUM_AXES],
  input  logic                                                  ignore_near,
  output logic signed [ENTRY_WIDTH:0]                           coef [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COLS],
  output logic signed [COORD_WIDTH-1:0]                         corner [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  output logic [fbc_pkg::NUM_PLANES-1:0]                        tested
);
  import fbc_pkg::*;

  localparam int CW = ENTRY_WIDTH + 1;

  logic signed [CW-1:0] coef_next [NUM_PLANES][NUM_COLS];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    localparam int K = p / 2;

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      logic signed [CW-1:0] w_e;
      logic signed [CW-1:0] r_e;
      assign w_e = CW'($signed(rows[W_ROW][SLOT_WIDTH*c +: ENTRY_WIDTH]));
      assign r_e = CW'($signed(rows[K][SLOT_WIDTH*c +: ENTRY_WIDTH]));
      if (p % 2 == 1) begin : g_minus
        assign coef_next[p][c] = w_e - r_e;
      end else begin : g_plus
        assign coef_next[p][c] = w_e + r_e;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          coef[p][c] <= coef_next[p][c];
        end
      end
    end

    // corner furthest along the normal: max unless the coefficient is negative
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      always_ff @(posedge clk) begin
        if (adv) begin
          corner[p][a] <= coef_next[p][a][CW-1] ? box_min[a] : box_max[a];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tested[p] <= (p == NEAR_PLANE) ? ~ignore_near : 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/fbc_plane_eval.sv
// ----------------------------------------------------------------------------
// fbc_plane_eval: exact sign of one plane equation at its corner
// three multipliers, two partial sums, then the final add and sign
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbc_plane_eval #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int ENTRY_WIDTH = fbc_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [ENTRY_WIDTH:0]   coef [fbc_pkg::NUM_COLS],
  input  logic signed [COORD_WIDTH-1:0] corner [fbc_pkg::NUM_AXES],
  input  logic                          tested,
  output logic                          neg
);
  import fbc_pkg::*;

  // product width and full-sum width (three products plus the offset term)
  localparam int PW = ENTRY_WIDTH + 1 + COORD_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod [NUM_AXES];
  logic signed [SW-1:0] dterm;
  logic                 tested_s2;
  logic signed [SW-1:0] sum_a;
  logic signed [SW-1:0] sum_b;
  logic                 tested_s3;
  logic signed [SW-1:0] total;

  // stage 2: products and scaled offset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod[a] <= PW'(coef[a]) * PW'(corner[a]);
      end
      dterm     <= SW'(coef[D_COL]) <<< FRAC_BITS;
      tested_s2 <= tested;
    end
  end

  // stage 3: partial sums
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_a     <= SW'(prod[0]) + SW'(prod[1]);
      sum_b     <= SW'(prod[2]) + dterm;
      tested_s3 <= tested_s2;
    end
  end

  assign total = sum_a + sum_b;

  // stage 4: sign of the plane value, forced low when the plane is not tested
  always_ff @(posedge clk) begin
    if (adv) begin
      neg <= tested_s3 & total[SW-1];
    end
  end

endmodule

`default_nettype wire

FILE: design/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull: view-frustum test of an axis-aligned box
// six planes from a view-projection matrix, p-vertex test on each plane
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, min_*, max_*,           box item in
//             ignore_near
//   output    out_valid/out_ready, visible               result item out
//   config    cfg_we, cfg_index, cfg_data                matrix row write
//
// one item per cycle sustained unless the output stalls; an accepted item
// passes the setup, multiply, partial sum and sign stages to out_valid
// the pipeline moves as a whole: it advances when the last stage is empty
// or its item is taken, so a stalled output holds every stage in place
// synchronous reset clears valid bits and restores the identity matrix
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frustum_box_cull #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int ENTRY_WIDTH = fbc_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [fbc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [fbc_pkg::REG_WIDTH-1:0]         cfg_data,
  // box item in
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         min_x,
  input  logic signed [COORD_WIDTH-1:0]         min_y,
  input  logic signed [COORD_WIDTH-1:0]         min_z,
  input  logic signed [COORD_WIDTH-1:0]         max_x,
  input  logic signed [COORD_WIDTH-1:0]         max_y,
  input  logic signed [COORD_WIDTH-1:0]         max_z,
  input  logic                                  ignore_near,
  // result item out
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  visible
);
  import fbc_pkg::*;

  localparam int NUM_STAGES = 4;

  // matrix rows, one register each
  logic [NUM_ROWS-1:0][REG_WIDTH-1:0] rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[REG_ROW_0] <= ROW_0_RESET;
      rows[REG_ROW_1] <= ROW_1_RESET;
      rows[REG_ROW_2] <= ROW_2_RESET;
      rows[REG_ROW_3] <= ROW_3_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ROW_0: rows[REG_ROW_0] <= cfg_data;
        REG_ROW_1: rows[REG_ROW_1] <= cfg_data;
        REG_ROW_2: rows[REG_ROW_2] <= cfg_data;
        REG_ROW_3: rows[REG_ROW_3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: one valid bit per stage, whole pipe advances together
  logic [NUM_STAGES-1:0] valid;
  logic                  adv;

  assign adv       = ~valid[NUM_STAGES-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[NUM_STAGES-2:0], in_valid};
    end
  end

  // box corners as arrays
  logic signed [COORD_WIDTH-1:0] box_min [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] box_max [NUM_AXES];

  assign box_min[0] = min_x;
  assign box_min[1] = min_y;
  assign box_min[2] = min_z;
  assign box_max[0] = max_x;
  assign box_max[1] = max_y;
  assign box_max[2] = max_z;

  // stage 1: plane coefficients, chosen corner and near-plane mask
  logic signed [ENTRY_WIDTH:0]   coef   [NUM_PLANES][NUM_COLS];
  logic signed [COORD_WIDTH-1:0] corner [NUM_PLANES][NUM_AXES];
  logic [NUM_PLANES-1:0]         tested;

  fbc_plane_setup #(
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_setup (
    .clk         (clk),
    .adv         (adv),
    .rows        (rows),
    .box_min     (box_min),
    .box_max     (box_max),
    .ignore_near (ignore_near),
    .coef        (coef),
    .corner      (corner),
    .tested      (tested)
  );

  // stages 2 to 4: one evaluation lane per plane
  logic [NUM_PLANES-1:0] neg;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbc_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_eval (
      .clk    (clk),
      .adv    (adv),
      .coef   (coef[p]),
      .corner (corner[p]),
      .tested (tested[p]),
      .neg    (neg[p])
    );
  end

  // culled if any tested plane has its far corner on the negative side
  assign visible = ~|neg;

endmodule

`default_nettype wire

FILE: design/fbc_checker.sv
// ----------------------------------------------------------------------------
// fbc_checker: port-level checks for the frustum box cull block
// watches the handshakes and reset behavior of the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible))
    else $error("result item changed while stalled");

  // a taken output always frees the input side
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  // the input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item presented after reset");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .visible   (visible)
);

`default_nettype wire
